[sv/u16u8_pkg.sv]
package u16u8_pkg;

  // One input transaction: a UTF-16 code unit and the end-of-string flag.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_t;

  // One output transaction: a UTF-8 byte and the end-of-run flag.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } utf8_t;

  // Up to three bytes for a code point in the basic plane, first byte in slot 0.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } bmp_enc_t;

  localparam int unsigned MaxBytes = 6;
  localparam logic [5:0]  HighTag  = 6'b110110;
  localparam logic [5:0]  LowTag   = 6'b110111;
  localparam logic [20:0] SuppBase = 21'h10000;

  function automatic bmp_enc_t enc_bmp(input logic [15:0] u);
    bmp_enc_t e;
    e.bytes = '0;
    if (u[15:7] == 9'd0) begin
      e.bytes[0] = {1'b0, u[6:0]};
      e.len      = 2'd1;
    end else if (u[15:11] == 5'd0) begin
      e.bytes[0] = {3'b110, u[10:6]};
      e.bytes[1] = {2'b10, u[5:0]};
      e.len      = 2'd2;
    end else begin
      e.bytes[0] = {4'b1110, u[15:12]};
      e.bytes[1] = {2'b10, u[11:6]};
      e.bytes[2] = {2'b10, u[5:0]};
      e.len      = 2'd3;
    end
    return e;
  endfunction

endpackage

[sv/utf16_to_utf8_transcoder.sv]
// UTF-16 to UTF-8 transcoder. Each input transaction carries one 16-bit code
// unit and a flag for the last unit of a string; each output transaction
// carries one UTF-8 byte, with run_end set on the last byte that a given input
// unit produced. A high surrogate that is not the last unit is held and
// produces nothing by itself; when the next unit is a low surrogate the pair
// is emitted as one four-byte sequence, otherwise the held surrogate is first
// emitted alone as three bytes. Unpaired surrogates, including a held one
// flushed by the last unit, become three-byte sequences. An input unit is
// taken into an input register, decoded combinationally into a byte buffer of
// up to six bytes, and the buffer drains one byte per cycle while the output
// is not stalled. An input unit yields one byte for ASCII, two or three for
// other basic plane characters, none for a high surrogate that is held, four
// for the low surrogate that completes the pair, and up to six when a stale
// high surrogate is flushed ahead of a new character. The output byte
// register is what sets the pace. The next unit is accepted while the last
// byte of the previous one is still being delivered, so a stream of ASCII
// runs at one transaction per cycle while the output is not stalled. There
// is no configuration and no memory to clear.
module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  unit_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output utf8_t out_data_o
);

  // Input register: one accepted transaction waiting for decode.
  logic       in_vld_q, in_vld_d;
  unit_t      in_q;

  // Surrogate holding state.
  logic       held_q, held_d;
  logic [9:0] offset_q, offset_d;

  // Byte buffer: slot 0 is the byte on the output, rem_q bytes are left.
  logic [MaxBytes-1:0][7:0] byte_q, byte_d;
  logic [2:0]               rem_q, rem_d;

  logic accept, pop, load;

  assign out_valid_o         = (rem_q != 3'd0);
  assign out_data_o.out_byte = byte_q[0];
  assign out_data_o.run_end  = (rem_q == 3'd1);

  assign pop  = out_valid_o & ~out_stall_i;
  // The buffer can take a new decode once it is empty or its final byte leaves.
  assign load = in_vld_q & ((rem_q == 3'd0) | ((rem_q == 3'd1) & ~out_stall_i));

  assign in_stall_o = in_vld_q & ~load;
  assign accept     = in_valid_i & ~in_stall_o;

  // Decode of the registered unit against the holding state.
  logic                     is_high, is_low, pair, flush, emit;
  logic [20:0]              cp;
  bmp_enc_t                 flush_enc, unit_enc;
  logic [MaxBytes-1:0][7:0] dec_bytes;
  logic [2:0]               dec_cnt;

  assign is_high = (in_q.code_unit[15:10] == HighTag);
  assign is_low  = (in_q.code_unit[15:10] == LowTag);
  assign pair    = held_q & is_low;
  assign flush   = held_q & ~is_low;
  assign emit    = ~pair & ~(is_high & ~in_q.last_unit);
  assign cp      = SuppBase + {1'b0, offset_q, in_q.code_unit[9:0]};

  assign flush_enc = enc_bmp({HighTag, offset_q});
  assign unit_enc  = enc_bmp(in_q.code_unit);

  always_comb begin
    dec_bytes = '0;
    dec_cnt   = 3'd0;
    if (pair) begin
      dec_bytes[0] = {5'b11110, cp[20:18]};
      dec_bytes[1] = {2'b10, cp[17:12]};
      dec_bytes[2] = {2'b10, cp[11:6]};
      dec_bytes[3] = {2'b10, cp[5:0]};
      dec_cnt      = 3'd4;
    end else if (flush) begin
      // A stale high surrogate always encodes to three bytes.
      dec_bytes[2:0] = flush_enc.bytes;
      dec_bytes[5:3] = unit_enc.bytes;
      dec_cnt        = emit ? (3'd3 + {1'b0, unit_enc.len}) : 3'd3;
    end else begin
      dec_bytes[2:0] = unit_enc.bytes;
      dec_cnt        = emit ? {1'b0, unit_enc.len} : 3'd0;
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (load) begin
      in_vld_d = 1'b0;
    end
    if (accept) begin
      in_vld_d = 1'b1;
    end

    byte_d   = byte_q;
    rem_d    = rem_q;
    held_d   = held_q;
    offset_d = offset_q;
    if (pop) begin
      byte_d = byte_q >> 8;
      rem_d  = rem_q - 3'd1;
    end
    if (load) begin
      byte_d = dec_bytes;
      rem_d  = dec_cnt;
      if (is_high & ~in_q.last_unit & ~pair) begin
        held_d   = 1'b1;
        offset_d = in_q.code_unit[9:0];
      end else begin
        held_d   = 1'b0;
        offset_d = 10'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      rem_q    <= 3'd0;
      held_q   <= 1'b0;
      offset_q <= 10'd0;
    end else begin
      in_vld_q <= in_vld_d;
      rem_q    <= rem_d;
      held_q   <= held_d;
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    byte_q <= byte_d;
  end

  // The byte buffer never claims more bytes than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rem_q <= 3'd6)
    else $error("byte buffer count out of range");

  // The last unit of a string always leaves nothing held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_q.last_unit) |=> !held_q)
    else $error("surrogate still held after last unit");

  // A unit that yields no bytes must be a high surrogate that is now held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && dec_cnt == 3'd0) |=> (held_q && !$past(in_q.last_unit)))
    else $error("unit dropped without being held");

endmodule
